// ----- rtl/core/imsd_pkg.sv -----
// Shared types and constants for the IMU magnitude and step detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package imsd_pkg;

   // Field widths
   localparam int AXIS_W  = 16;
   localparam int TIME_W  = 32;
   localparam int MAG_W   = 16;
   localparam int COUNT_W = 16;
   localparam int POS_W   = 7;
   localparam int CSR_W   = 16;

   // Window geometry
   localparam int WINDOW_LEN = 128;
   localparam int SLOT_W     = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA      = 2'd2;

   // Register reset values
   localparam logic [CSR_W-1:0] THRESHOLD_RESET = 16'd1639;
   localparam logic [CSR_W-1:0] INTERVAL_RESET  = 16'd250;
   localparam logic [CSR_W-1:0] ALPHA_RESET     = 16'd66;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
      logic signed [AXIS_W-1:0] gyro_x;
      logic signed [AXIS_W-1:0] gyro_y;
      logic signed [AXIS_W-1:0] gyro_z;
      logic [TIME_W-1:0]        time_ms;
   } req_payload_type;

   typedef struct packed {
      logic [MAG_W-1:0]   accel_mag;
      logic [MAG_W-1:0]   gyro_mag;
      logic               step_detected;
      logic [COUNT_W-1:0] step_count;
      logic [POS_W-1:0]   window_position;
      logic               window_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      MAG_IDLE,
      MAG_SQUARE,
      MAG_ROOT
   } mag_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_BASE,
      ST_DEV,
      ST_DECIDE,
      ST_WAIT
   } step_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/imsd_req_if.sv -----
// Sample channel: valid/ready handshake carrying one six-axis sample per beat.
// Depends on imsd_pkg for the payload type.
`default_nettype none

interface imsd_req_if;
   import imsd_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/imsd_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one result per beat.
// Depends on imsd_pkg for the payload type.
`default_nettype none

interface imsd_rsp_if;
   import imsd_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/imu_magnitude_step_detector.sv -----
// Top level of the IMU magnitude and step detector: handshakes, registers,
// EMA baseline, step decision and window slot. Depends on imsd_pkg,
// imsd_req_if, imsd_rsp_if and imsd_mag.
//
//   channel   | dir | handshake          | beat content
//   ----------+-----+--------------------+------------------------------------
//   req_chan  | in  | valid/ready        | six raw axes and time_ms
//   rsp_chan  | out | valid/ready        | magnitudes, step flag/count, slot
//   csr_*     | in  | csr_we, no ready   | register index and 16-bit value
//
// A new sample is taken only once the previous result is loaded; each result
// waits on the 16-step bit-serial squaring and the 16-step root in imsd_mag,
// and the EMA multiply runs bit-serially alongside them.
// Synchronous active-high reset clears control and step state and loads the register reset values.
// A result held on a stalled rsp_chan does not block the next sample; only
// the following result waits for the output register to drain.
`default_nettype none

module imu_magnitude_step_detector (
   input  wire logic                         clock,
   input  wire logic                         reset,
   imsd_req_if.sink                          req_chan,
   imsd_rsp_if.source                        rsp_chan,
   input  wire logic                         csr_we,
   input  wire logic [imsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [imsd_pkg::CSR_W-1:0]   csr_wdata
);
   import imsd_pkg::*;

   // Configuration registers
   logic [CSR_W-1:0] thr_ff, interval_ff, alpha_ff;

   // Persistent step state
   logic signed [31:0] base_ff;
   logic               armed_ff;
   logic [TIME_W-1:0]  last_ms_ff;
   logic [COUNT_W-1:0] total_ff;
   logic [SLOT_W-1:0]  slot_ff;

   // Per-sample working registers
   step_state_type     state_ff, state_in;
   logic [3:0]         cnt_ff;
   logic signed [AXIS_W-1:0] az_ff;
   logic [TIME_W-1:0]  now_ff;
   logic signed [32:0] dmul_ff;
   logic [CSR_W-1:0]   amul_ff;
   logic signed [33:0] hi_ff;
   logic [15:0]        lo_ff;
   logic [32:0]        devabs_ff;
   logic               det_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               wend_ff;

   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   logic               accept;
   logic               mag_done_a, mag_done_g;
   logic [MAG_W-1:0]   mag_a, mag_g;
   logic               out_free;
   logic               mul_step, base_step, dev_step, decide_step, rsp_load;

   logic signed [32:0] z_in33, d_in;
   logic signed [33:0] addend, sum_hi;
   logic [33:0]        base_sum;
   logic signed [32:0] z33, dev;
   logic               over, under, late;
   logic [TIME_W-1:0]  elapsed;

   assign accept = req_chan.valid && req_chan.ready;

   // Configuration writes; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THRESHOLD_RESET;
         interval_ff <= INTERVAL_RESET;
         alpha_ff    <= ALPHA_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_THRESHOLD: thr_ff      <= csr_wdata;
            CSR_MIN_INTERVAL:   interval_ff <= csr_wdata;
            CSR_EMA_ALPHA:      alpha_ff    <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Magnitude units, one per vector
   imsd_mag u_mag_accel (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .axis_a    (req_chan.data.accel_x),
      .axis_b    (req_chan.data.accel_y),
      .axis_c    (req_chan.data.accel_z),
      .done      (mag_done_a),
      .magnitude (mag_a)
   );

   imsd_mag u_mag_gyro (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .axis_a    (req_chan.data.gyro_x),
      .axis_b    (req_chan.data.gyro_y),
      .axis_c    (req_chan.data.gyro_z),
      .done      (mag_done_g),
      .magnitude (mag_g)
   );

   assign out_free = mag_done_a && mag_done_g && (!rsp_valid_ff || rsp_chan.ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MUL;
         ST_MUL:    if (cnt_ff == 4'hF) state_in = ST_BASE;
         ST_BASE:   state_in = ST_DEV;
         ST_DEV:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_WAIT;
         ST_WAIT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_chan.ready = 1'b0;
      mul_step       = 1'b0;
      base_step      = 1'b0;
      dev_step       = 1'b0;
      decide_step    = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_MUL:    mul_step       = 1'b1;
         ST_BASE:   base_step      = 1'b1;
         ST_DEV:    dev_step       = 1'b1;
         ST_DECIDE: decide_step    = 1'b1;
         ST_WAIT:   rsp_load       = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) cnt_ff <= '0;
         else if (mul_step) cnt_ff <= cnt_ff + 4'd1;
      end
   end

   // EMA datapath: d = Z - baseline, alpha * d by shift-add, one alpha bit a cycle
   assign z_in33 = {req_chan.data.accel_z[AXIS_W-1], req_chan.data.accel_z, 16'b0};
   assign d_in   = z_in33 - {base_ff[31], base_ff};
   assign addend = amul_ff[0] ? {dmul_ff[32], dmul_ff} : '0;
   assign sum_hi = hi_ff + addend;

   // Round half up: add bit 15 of the product to its upper part
   assign base_sum = {{2{base_ff[31]}}, base_ff} + hi_ff + {33'b0, lo_ff[15]};

   // Deviation after the update
   assign z33 = {az_ff[AXIS_W-1], az_ff, 16'b0};
   assign dev = z33 - {base_ff[31], base_ff};

   // Step decision terms
   assign over    = devabs_ff > {1'b0, thr_ff, 16'b0};
   assign under   = {devabs_ff, 1'b0} < {2'b0, thr_ff, 16'b0};
   assign elapsed = now_ff - last_ms_ff;
   assign late    = elapsed > {16'b0, interval_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         az_ff   <= req_chan.data.accel_z;
         now_ff  <= req_chan.data.time_ms;
         dmul_ff <= d_in;
         amul_ff <= alpha_ff;
         hi_ff   <= '0;
         lo_ff   <= '0;
      end else if (mul_step) begin
         amul_ff <= amul_ff >> 1;
         hi_ff   <= sum_hi >>> 1;
         lo_ff   <= {sum_hi[0], lo_ff[15:1]};
      end
      if (dev_step) begin
         devabs_ff <= dev[32] ? 33'(-dev) : dev;
      end
   end

   // Persistent state: baseline, arming, last step time, count, slot
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         armed_ff   <= 1'b0;
         last_ms_ff <= '0;
         total_ff   <= '0;
         slot_ff    <= '0;
      end else begin
         if (base_step) base_ff <= base_sum[31:0];
         if (decide_step) begin
            if (slot_ff >= SLOT_LAST) slot_ff <= '0;
            else slot_ff <= slot_ff + 1'b1;
            priority if (over && !armed_ff) begin
               armed_ff <= 1'b1;
               if (late) begin
                  last_ms_ff <= now_ff;
                  if (total_ff != COUNT_MAX) total_ff <= total_ff + 1'b1;
               end
            end else if (under) begin
               armed_ff <= 1'b0;
            end
         end
      end
   end

   // Per-sample flags for the result beat
   always_ff @(posedge clock) begin
      if (decide_step) begin
         det_ff  <= over && !armed_ff && late;
         pos_ff  <= POS_W'(slot_ff);
         wend_ff <= (slot_ff >= SLOT_LAST);
      end
   end

   // Output register: load a finished result, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.accel_mag       <= mag_a;
         rsp_data_ff.gyro_mag        <= mag_g;
         rsp_data_ff.step_detected   <= det_ff;
         rsp_data_ff.step_count      <= total_ff;
         rsp_data_ff.window_position <= pos_ff;
         rsp_data_ff.window_end      <= wend_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/imsd_mag.sv -----
// Vector magnitude unit: bit-serial sum of three squares, then a bit-serial
// integer square root. Depends on imsd_pkg.
`default_nettype none

module imsd_mag (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [imsd_pkg::AXIS_W-1:0] axis_a,
   input  wire logic signed [imsd_pkg::AXIS_W-1:0] axis_b,
   input  wire logic signed [imsd_pkg::AXIS_W-1:0] axis_c,
   output logic                              done,
   output logic [imsd_pkg::MAG_W-1:0]        magnitude
);
   import imsd_pkg::*;

   mag_state_type state_ff, state_in;
   logic [3:0]    cnt_ff;
   logic          done_ff;
   logic          sq_step, rt_step;

   logic [AXIS_W-1:0] mcand_a_ff, mcand_b_ff, mcand_c_ff;
   logic [AXIS_W-1:0] mplier_a_ff, mplier_b_ff, mplier_c_ff;
   logic [34:0]       prod_ff;
   logic [16:0]       rem_ff;
   logic [15:0]       root_ff;

   logic [AXIS_W-1:0] abs_a, abs_b, abs_c;
   logic [17:0]       addend;
   logic [19:0]       sum_hi;
   logic [18:0]       rem_cat;
   logic [18:0]       trial;
   logic [18:0]       rem_diff;

   // Take absolute values; the most negative code maps to 2^15 unsigned
   assign abs_a = axis_a[AXIS_W-1] ? AXIS_W'(-axis_a) : axis_a;
   assign abs_b = axis_b[AXIS_W-1] ? AXIS_W'(-axis_b) : axis_b;
   assign abs_c = axis_c[AXIS_W-1] ? AXIS_W'(-axis_c) : axis_c;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MAG_IDLE: begin
            if (start) state_in = MAG_SQUARE;
         end
         MAG_SQUARE: begin
            if (cnt_ff == 4'hF) state_in = MAG_ROOT;
         end
         MAG_ROOT: begin
            if (cnt_ff == 4'hF) state_in = MAG_IDLE;
         end
         default: state_in = MAG_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      sq_step = 1'b0;
      rt_step = 1'b0;
      unique case (state_ff)
         MAG_IDLE:   ;
         MAG_SQUARE: sq_step = 1'b1;
         MAG_ROOT:   rt_step = 1'b1;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAG_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start && state_ff == MAG_IDLE) begin
            cnt_ff  <= '0;
            done_ff <= 1'b0;
         end else if (sq_step || rt_step) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (rt_step && cnt_ff == 4'hF) done_ff <= 1'b1;
         end
      end
   end

   // Squaring: add the selected multiplicands to the high half, shift right
   assign addend = 18'(mplier_a_ff[0] ? mcand_a_ff : '0)
                 + 18'(mplier_b_ff[0] ? mcand_b_ff : '0)
                 + 18'(mplier_c_ff[0] ? mcand_c_ff : '0);
   assign sum_hi = {1'b0, prod_ff[34:16]} + 20'(addend);

   // Root: bring down two radicand bits, try subtracting 4*root+1
   assign rem_cat  = {rem_ff, prod_ff[31:30]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign rem_diff = rem_cat - trial;

   always_ff @(posedge clock) begin
      if (start && state_ff == MAG_IDLE) begin
         mcand_a_ff  <= abs_a;
         mcand_b_ff  <= abs_b;
         mcand_c_ff  <= abs_c;
         mplier_a_ff <= abs_a;
         mplier_b_ff <= abs_b;
         mplier_c_ff <= abs_c;
         prod_ff     <= '0;
         rem_ff      <= '0;
         root_ff     <= '0;
      end else if (sq_step) begin
         mplier_a_ff <= mplier_a_ff >> 1;
         mplier_b_ff <= mplier_b_ff >> 1;
         mplier_c_ff <= mplier_c_ff >> 1;
         prod_ff     <= 35'({sum_hi, prod_ff[15:0]} >> 1);
      end else if (rt_step) begin
         prod_ff <= prod_ff << 2;
         if (rem_cat >= trial) begin
            rem_ff  <= rem_diff[16:0];
            root_ff <= {root_ff[14:0], 1'b1};
         end else begin
            rem_ff  <= rem_cat[16:0];
            root_ff <= {root_ff[14:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign magnitude = root_ff;

endmodule

`default_nettype wire

// ----- verif/imsd_tb_pkg.sv -----
`timescale 1ns / 100ps
// Result tracker for the IMU magnitude and step detector testbench: register
// shadow, step state and the queue of expected results. Depends on imsd_pkg.
package imsd_tb_pkg;
   import imsd_pkg::*;

   class magnitude_step_tracker;
      // Register shadow
      logic [CSR_W-1:0]          threshold;
      logic [CSR_W-1:0]          interval;
      logic [CSR_W-1:0]          alpha;
      // Detector state
      logic signed [31:0]        z_base;
      bit                        armed;
      logic [TIME_W-1:0]         last_step;
      logic [COUNT_W-1:0]        total;
      int unsigned               slot;
      rsp_payload_type           pending_results[$];
      int unsigned               mismatch_count;

      function new();
         threshold      = THRESHOLD_RESET;
         interval       = INTERVAL_RESET;
         alpha          = ALPHA_RESET;
         z_base         = '0;
         armed          = 1'b0;
         last_step      = '0;
         total          = '0;
         slot           = 0;
         mismatch_count = 0;
      endfunction

      // Mirror a register write; unknown indexes are dropped.
      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_STEP_THRESHOLD: threshold = val;
            CSR_MIN_INTERVAL:   interval  = val;
            CSR_EMA_ALPHA:      alpha     = val;
            default: ;
         endcase
      endfunction

      // Truncated square root of a three-axis sum of squares, bit by bit.
      function logic [MAG_W-1:0] root_of_squares(logic signed [AXIS_W-1:0] a,
                                                 logic signed [AXIS_W-1:0] b,
                                                 logic signed [AXIS_W-1:0] c);
         longint           sum;
         longint           cand;
         logic [MAG_W-1:0] root;
         sum  = longint'(a) * a + longint'(b) * b + longint'(c) * c;
         root = '0;
         for (int i = MAG_W - 1; i >= 0; i--) begin
            cand = longint'(root) | (longint'(1) << i);
            if (cand * cand <= sum) begin
               root[i] = 1'b1;
            end
         end
         return root;
      endfunction

      // Advance the detector by one sample and return its result beat.
      function rsp_payload_type predict_result(req_payload_type s);
         rsp_payload_type   r;
         longint            z_fx;
         longint            step_inc;
         longint            dev;
         longint            thr_fx;
         logic [TIME_W-1:0] elapsed;
         r = '0;
         r.accel_mag = root_of_squares(s.accel_x, s.accel_y, s.accel_z);
         r.gyro_mag  = root_of_squares(s.gyro_x, s.gyro_y, s.gyro_z);

         // Window slot
         r.window_position = POS_W'(slot);
         r.window_end      = (slot >= WINDOW_LEN - 1);
         slot              = r.window_end ? 0 : slot + 1;

         // Baseline moves by alpha times the error, rounded half up
         z_fx     = longint'(s.accel_z) * 65536;
         step_inc = (longint'(alpha) * (z_fx - longint'(z_base)) + 32768) >>> 16;
         z_base   = z_base + 32'(step_inc);

         // Trigger above threshold, release below half of it
         dev = z_fx - longint'(z_base);
         if (dev < 0) begin
            dev = -dev;
         end
         thr_fx = longint'(threshold) * 65536;
         if (dev > thr_fx && !armed) begin
            elapsed = s.time_ms - last_step;
            if (elapsed > TIME_W'(interval)) begin
               r.step_detected = 1'b1;
               if (total != COUNT_MAX) begin
                  total = total + 1'b1;
               end
               last_step = s.time_ms;
            end
            armed = 1'b1;
         end else if (dev * 2 < thr_fx) begin
            armed = 1'b0;
         end
         r.step_count = total;
         return r;
      endfunction

      function void note_sample(req_payload_type s);
         pending_results.push_back(predict_result(s));
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
         end
      endfunction

      // Match one result beat against the oldest expectation.
      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %h", $time, got);
            mismatch_count++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("accel_mag", 32'(want.accel_mag), 32'(got.accel_mag));
         compare_field("gyro_mag", 32'(want.gyro_mag), 32'(got.gyro_mag));
         compare_field("step_detected", 32'(want.step_detected), 32'(got.step_detected));
         compare_field("step_count", 32'(want.step_count), 32'(got.step_count));
         compare_field("window_position", 32'(want.window_position),
                       32'(got.window_position));
         compare_field("window_end", 32'(want.window_end), 32'(got.window_end));
      endfunction
   endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for imu_magnitude_step_detector: drives samples and
// register writes, tracks expected results. Depends on imsd_pkg, the channel
// interfaces and imsd_tb_pkg.
module tb_top;
   import imsd_pkg::*;
   import imsd_tb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   imsd_req_if req_chan();
   imsd_rsp_if rsp_chan();

   magnitude_step_tracker tracker = new();

   bit                idle_on;
   bit                hold_request;
   int                stride_pos;
   int                stride_len;
   int                stride_amp;
   bit                stride_down;
   logic [TIME_W-1:0] walk_time;

   imu_magnitude_step_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Result side: check each beat, then pick ready for the next cycle.
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            tracker.check_result(rsp_chan.data);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic req_payload_type pack_sample(int ax, int ay, int az, int gx, int gy,
                                                   int gz, logic [TIME_W-1:0] t);
      req_payload_type s;
      s.accel_x = AXIS_W'(ax);
      s.accel_y = AXIS_W'(ay);
      s.accel_z = AXIS_W'(az);
      s.gyro_x  = AXIS_W'(gx);
      s.gyro_y  = AXIS_W'(gy);
      s.gyro_z  = AXIS_W'(gz);
      s.time_ms = t;
      return s;
   endfunction

   // Walking pattern: a peak on accel z around the current baseline every
   // few samples, timestamps advancing by 12 to 30 ms with an occasional large jump.
   function automatic req_payload_type next_stride_sample();
      int center;
      int z;
      int thr;
      center = tracker.z_base >>> 16;
      if (stride_pos == 0) begin
         thr         = int'(tracker.threshold);
         stride_len  = $urandom_range(6, 20);
         stride_down = 1'($urandom_range(0, 1));
         stride_amp  = (thr == 0) ? int'($urandom_range(0, 600))
                                  : thr * int'($urandom_range(40, 300)) / 100;
         if (stride_amp > 30000) begin
            stride_amp = 30000;
         end
      end
      z = center + int'($urandom_range(0, 200)) - 100;
      if (stride_pos == 0) begin
         z += stride_down ? -(stride_amp / 2) : stride_amp / 2;
      end else if (stride_pos == 1) begin
         z += stride_down ? -stride_amp : stride_amp;
      end
      if (z > 32767) begin
         z = 32767;
      end else if (z < -32768) begin
         z = -32768;
      end
      stride_pos = (stride_pos + 1 >= stride_len) ? 0 : stride_pos + 1;
      walk_time += $urandom_range(12, 30);
      if ($urandom_range(0, 40) == 0) begin
         walk_time += $urandom;
      end
      return pack_sample(int'($urandom_range(0, 8000)) - 4000,
                         int'($urandom_range(0, 8000)) - 4000, z,
                         int'($urandom), int'($urandom), int'($urandom), walk_time);
   endfunction

   // Offer one sample and hold it until the beat is taken.
   task automatic send_sample(input req_payload_type s);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_sample(s);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Write all registers plus one unmapped index; only while idle.
   task automatic program_registers(input logic [CSR_W-1:0] thr,
                                    input logic [CSR_W-1:0] ivl,
                                    input logic [CSR_W-1:0] alpha);
      logic [CSR_W-1:0] junk;
      junk = CSR_W'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_STEP_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      tracker.set_register(CSR_STEP_THRESHOLD, thr);
      csr_index <= CSR_MIN_INTERVAL;
      csr_wdata <= ivl;
      @(posedge clock);
      tracker.set_register(CSR_MIN_INTERVAL, ivl);
      csr_index <= CSR_EMA_ALPHA;
      csr_wdata <= alpha;
      @(posedge clock);
      tracker.set_register(CSR_EMA_ALPHA, alpha);
      csr_index <= CSR_UNUSED;
      csr_wdata <= junk;
      @(posedge clock);
      tracker.set_register(CSR_UNUSED, junk);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One register setting: mostly strides, some raw noise beats.
   task automatic run_phase(input logic [CSR_W-1:0] thr, input logic [CSR_W-1:0] ivl,
                            input logic [CSR_W-1:0] alpha, input int count,
                            input bit quiet, input bit with_hold);
      req_payload_type s;
      program_registers(thr, ivl, alpha);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
         end
         if (with_hold && n == 40) begin
            hold_request = 1'b1;
         end
         if ($urandom_range(0, 4) == 0) begin
            s = {$urandom, $urandom, $urandom, $urandom};
         end else begin
            s = next_stride_sample();
         end
         send_sample(s);
      end
      drain_results();
   endtask

   initial begin
      req_payload_type directed_set[$];
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      stride_pos   = 0;
      stride_len   = 8;
      stride_amp   = 0;
      stride_down  = 1'b0;
      walk_time    = 32'd1000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, interval boundary and timestamp wrap
      directed_set.push_back(pack_sample(0, 0, 0, 0, 0, 0, 32'd0));
      directed_set.push_back(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768,
                                         32'd0));
      directed_set.push_back(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 32'd100));
      directed_set.push_back(pack_sample(32767, -32768, 0, -32768, 32767, 1, 32'd200));
      directed_set.push_back(pack_sample(0, 0, 16384, 0, 0, 0, 32'd300));
      directed_set.push_back(pack_sample(0, 0, 0, 0, 0, 0, 32'd310));
      // inside the refractory interval
      directed_set.push_back(pack_sample(0, 0, 16384, 0, 0, 0, 32'd400));
      directed_set.push_back(pack_sample(0, 0, 0, 0, 0, 0, 32'd500));
      // downward deviation just past the interval
      directed_set.push_back(pack_sample(0, 0, -16384, 0, 0, 0, 32'd551));
      directed_set.push_back(pack_sample(0, 0, 0, 0, 0, 0, 32'd560));
      // timestamp before the last step wraps to a large gap
      directed_set.push_back(pack_sample(0, 0, 16384, 0, 0, 0, 32'd5));
      directed_set.push_back(pack_sample(0, 0, 0, 0, 0, 0, 32'hFFFF_FFF0));
      directed_set.push_back(pack_sample(0, 0, 16384, 0, 0, 0, 32'hFFFF_FFFF));
      directed_set.push_back(pack_sample(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      // gap of exactly the interval across the wrap: no step
      directed_set.push_back(pack_sample(0, 0, 16384, 0, 0, 0, 32'd249));
      directed_set.push_back(pack_sample(0, 0, 0, 0, 0, 0, 32'd300));
      directed_set.push_back(pack_sample(0, 0, 0, -32768, -32768, -32768, 32'd320));
      directed_set.push_back(pack_sample(1, -1, 1, 0, 0, -1, 32'd340));
      directed_set.push_back(pack_sample(3, 4, 0, -3, 0, 4, 32'd360));
      directed_set.push_back(pack_sample(-1, -1, -1, 32767, 0, -32768, 32'h8000_0000));
      foreach (directed_set[k]) begin
         send_sample(directed_set[k]);
      end
      drain_results();

      // Random phases across register settings, extremes included
      run_phase(THRESHOLD_RESET, INTERVAL_RESET, ALPHA_RESET, 300, 1'b0, 1'b1);
      run_phase(16'd0, 16'd0, 16'hFFFF, 200, 1'b0, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'd0, 150, 1'b0, 1'b0);
      run_phase(CSR_W'($urandom_range(200, 4000)), CSR_W'($urandom_range(50, 400)),
                CSR_W'($urandom_range(200, 8000)), 300, 1'b0, 1'b0);
      run_phase(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom), 150, 1'b0, 1'b0);
      run_phase(THRESHOLD_RESET, CSR_W'($urandom_range(100, 300)), 16'd2000, 300,
                1'b1, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/imsd_pkg.sv
rtl/core/imsd_req_if.sv
rtl/core/imsd_rsp_if.sv
rtl/core/imsd_mag.sv
rtl/core/imu_magnitude_step_detector.sv
verif/imsd_tb_pkg.sv
verif/tb_top.sv
